// ===== design/hacsl_pkg.sv =====
// Package: shared constants, coefficient and reorder tables, microcode for the Hall angle block
`timescale 1ns / 1ps
package hacsl_pkg;

	localparam int CHANNELS_DEF  = 16;
	localparam int ADC_BITS_DEF  = 12;
	localparam int FRAC_BITS_DEF = 8;

	localparam int SLOT_W     = 4;
	localparam int ANGLE_W    = 24;
	localparam int LIMIT_W    = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam int COEF_SHIFT = 32;
	localparam int MUL_A_W    = 21;
	localparam int T_W        = 40;
	localparam int T_SPLIT    = 20;
	localparam int ACC_W      = 64;
	localparam int B_W        = 33;
	localparam int DEG_LIMIT  = 10000;

	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7fffff;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 24'sh800000;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_ENABLE = 4'd1;

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_MUL_A = 3'd1;
	localparam logic [STEP_W-1:0] STEP_T_LO  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_T_HI  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_ROUND = 3'd4;
	localparam logic [STEP_W-1:0] STEP_SLEW  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd6;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_COEF_A,
		MUL_T_LO,
		MUL_T_HI
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD_T,
		ACC_LOAD_C,
		ACC_ADD_HI
	} acc_op_t;

	typedef struct packed {
		mul_sel_t          mul;
		acc_op_t           acc;
		logic              wait_in;
		logic              jump_bad;
		logic              do_round;
		logic              do_slew;
		logic              do_emit;
		logic [STEP_W-1:0] nxt;
	} ctrl_word_t;

	typedef struct packed {
		ctrl_word_t cw;
		logic       accept;
		logic       emit_go;
	} seq_ctrl_t;

	typedef struct packed {
		logic slot_ok;
		logic out_busy;
	} dp_status_t;

	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t w;
		begin
			w = '{mul: MUL_NONE, acc: ACC_HOLD, wait_in: 1'b0, jump_bad: 1'b0,
				do_round: 1'b0, do_slew: 1'b0, do_emit: 1'b0, nxt: STEP_WAIT};
			unique case (step)
				STEP_WAIT: begin
					w.wait_in = 1'b1;
					w.nxt     = STEP_MUL_A;
				end
				STEP_MUL_A: begin
					w.mul      = MUL_COEF_A;
					w.acc      = ACC_LOAD_T;
					w.jump_bad = 1'b1;
					w.nxt      = STEP_T_LO;
				end
				STEP_T_LO: begin
					w.mul = MUL_T_LO;
					w.acc = ACC_LOAD_C;
					w.nxt = STEP_T_HI;
				end
				STEP_T_HI: begin
					w.mul = MUL_T_HI;
					w.acc = ACC_ADD_HI;
					w.nxt = STEP_ROUND;
				end
				STEP_ROUND: begin
					w.do_round = 1'b1;
					w.nxt      = STEP_SLEW;
				end
				STEP_SLEW: begin
					w.do_slew = 1'b1;
					w.nxt     = STEP_EMIT;
				end
				STEP_EMIT: begin
					w.do_emit = 1'b1;
					w.nxt     = STEP_WAIT;
				end
				default: begin
					w.nxt = STEP_WAIT;
				end
			endcase
			return w;
		end
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of_channel(input logic [SLOT_W-1:0] ch);
		logic [SLOT_W-1:0] s;
		begin
			case (ch)
				4'd0:    s = 4'd14;
				4'd1:    s = 4'd12;
				4'd2:    s = 4'd13;
				4'd3:    s = 4'd15;
				4'd4:    s = 4'd10;
				4'd5:    s = 4'd11;
				4'd6:    s = 4'd9;
				4'd7:    s = 4'd7;
				4'd8:    s = 4'd8;
				4'd9:    s = 4'd6;
				4'd10:   s = 4'd4;
				4'd11:   s = 4'd5;
				4'd12:   s = 4'd3;
				4'd13:   s = 4'd2;
				4'd14:   s = 4'd1;
				default: s = 4'd0;
			endcase
			return s;
		end
	endfunction

	// set 0 .. 3 of the coefficient table; slot picks one
	function automatic logic [1:0] coef_set(input logic [SLOT_W-1:0] slot);
		logic [1:0] k;
		begin
			case (slot)
				4'd0, 4'd3, 4'd6, 4'd9, 4'd13: k = 2'd0;
				4'd1, 4'd4, 4'd7, 4'd10:       k = 2'd1;
				4'd12:                         k = 2'd3;
				4'd15:                         k = 2'd2;
				default:                       k = 2'd2;
			endcase
			return k;
		end
	endfunction

	function automatic logic signed [MUL_A_W-1:0] coef_a(input logic [SLOT_W-1:0] slot);
		logic signed [MUL_A_W-1:0] v;
		begin
			v = '0;
			case (coef_set(slot))
				2'd0: v = 21'sd805306;
				2'd1: v = -21'sd218290;
				2'd2: v = (slot == 4'd15) ? 21'sd167336 : 21'sd190642;
				2'd3: v = 21'sd208425;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	function automatic logic signed [B_W-1:0] coef_b(input logic [SLOT_W-1:0] slot);
		logic signed [ACC_W-1:0] v;
		begin
			v = '0;
			case (coef_set(slot))
				2'd0: v = -64'sd3865470566;
				2'd1: v = 64'sd1404175012;
				2'd2: v = (slot == 4'd15) ? -64'sd1159641170 : -64'sd1230285015;
				2'd3: v = -64'sd1365516867;
				default: v = '0;
			endcase
			return v[B_W-1:0];
		end
	endfunction

	function automatic logic signed [ACC_W-1:0] coef_c(input logic [SLOT_W-1:0] slot);
		logic signed [ACC_W-1:0] v;
		begin
			v = '0;
			case (coef_set(slot))
				2'd0: v = 64'sd4823785144320;
				2'd1: v = -64'sd1483942464201;
				2'd2: v = (slot == 4'd15) ? 64'sd1975238725792 : 64'sd1983929149486;
				2'd3: v = 64'sd2230305954334;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

// ===== design/hacsl_if.sv =====
// Interfaces: sample, result and configuration channels
`timescale 1ns / 1ps
interface hacsl_in_if #(
	parameter int ADC_BITS = hacsl_pkg::ADC_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [hacsl_pkg::SLOT_W-1:0]  mux_channel;
	logic [ADC_BITS-1:0]           raw_sample;

	modport source (output valid, output mux_channel, output raw_sample, input ready);
	modport sink   (input valid, input mux_channel, input raw_sample, output ready);
endinterface

interface hacsl_out_if;
	logic                                valid;
	logic                                ready;
	logic [hacsl_pkg::SLOT_W-1:0]        joint_slot;
	logic signed [hacsl_pkg::ANGLE_W-1:0] joint_angle;
	logic                                was_limited;
	logic signed [hacsl_pkg::ANGLE_W-1:0] min_seen;
	logic signed [hacsl_pkg::ANGLE_W-1:0] max_seen;

	modport source (output valid, output joint_slot, output joint_angle, output was_limited,
		output min_seen, output max_seen, input ready);
	modport sink   (input valid, input joint_slot, input joint_angle, input was_limited,
		input min_seen, input max_seen, output ready);
endinterface

interface hacsl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [hacsl_pkg::CFG_IDX_W-1:0]  index;
	logic [hacsl_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/hacsl_seq.sv =====
// Microcode sequencer: step counter, program table lookup, conditional jumps
`timescale 1ns / 1ps
module hacsl_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  hacsl_pkg::dp_status_t status,
	output hacsl_pkg::seq_ctrl_t  ctrl
);
	import hacsl_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	ctrl_word_t        cw;

	always_comb begin
		cw           = ucode(step_q);
		sample_ready = cw.wait_in;
		ctrl.cw      = cw;
		ctrl.accept  = sample_valid & cw.wait_in;
		ctrl.emit_go = cw.do_emit & ~status.out_busy;
		step_d       = cw.nxt;
		if (cw.wait_in && !sample_valid) begin
			step_d = step_q;
		end else if (cw.jump_bad && !status.slot_ok) begin
			step_d = STEP_EMIT;
		end else if (cw.do_emit && status.out_busy) begin
			step_d = step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== design/hacsl_datapath.sv =====
// Datapath: shared multiplier, accumulator, rounding, slew limit, per-slot state, result register
`timescale 1ns / 1ps
module hacsl_datapath #(
	parameter int CHANNELS  = hacsl_pkg::CHANNELS_DEF,
	parameter int ADC_BITS  = hacsl_pkg::ADC_BITS_DEF,
	parameter int FRAC_BITS = hacsl_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hacsl_pkg::seq_ctrl_t            ctrl,
	output hacsl_pkg::dp_status_t           status,
	input  logic [hacsl_pkg::SLOT_W-1:0]    mux_channel,
	input  logic [ADC_BITS-1:0]             raw_sample,
	input  logic [hacsl_pkg::LIMIT_W-1:0]   step_limit,
	input  logic                            cal_enable,
	hacsl_out_if.source                     result
);
	import hacsl_pkg::*;

	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int X_W    = ADC_BITS + 1;
	localparam int PROD_W = MUL_A_W + X_W;
	localparam int RND_S  = COEF_SHIFT - FRAC_BITS;
	localparam int DIFF_W = ANGLE_W + 2;
	localparam longint LO_RST_L = longint'(DEG_LIMIT) * (longint'(1) << FRAC_BITS);
	localparam logic signed [ANGLE_W-1:0] LO_RST =
		(LO_RST_L > longint'(8388607)) ? ANGLE_MAX : ANGLE_W'(LO_RST_L);
	localparam logic signed [ANGLE_W-1:0] HI_RST =
		(-LO_RST_L < longint'(-8388608)) ? ANGLE_MIN : ANGLE_W'(-LO_RST_L);
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (RND_S - 1));

	logic [SLOT_W-1:0]                slot_q;
	logic [ADC_BITS-1:0]              x_q;
	logic                             slot_ok_q;
	logic signed [T_W-1:0]            t_q;
	logic signed [ACC_W-1:0]          acc_q;
	logic signed [ANGLE_W-1:0]        angle_q;
	logic signed [ANGLE_W-1:0]        new_held_q;
	logic                             limited_q;
	logic signed [ANGLE_W-1:0]        held_q [CHANNELS];
	logic signed [ANGLE_W-1:0]        lo_q [CHANNELS];
	logic signed [ANGLE_W-1:0]        hi_q [CHANNELS];
	logic                             out_valid_q;
	logic [SLOT_W-1:0]                out_slot_q;
	logic signed [ANGLE_W-1:0]        out_angle_q;
	logic                             out_limited_q;
	logic signed [ANGLE_W-1:0]        out_min_q;
	logic signed [ANGLE_W-1:0]        out_max_q;

	logic [SLOT_W-1:0]                slot_in;
	logic [IDX_W-1:0]                 idx;
	logic signed [MUL_A_W-1:0]        mul_a;
	logic signed [X_W-1:0]            mul_b;
	logic signed [PROD_W-1:0]         prod;
	logic signed [T_W-1:0]            prod_t;
	logic signed [ACC_W-1:0]          prod_acc;
	logic signed [B_W-1:0]            b_coef;
	logic signed [T_W-1:0]            b_t;
	logic signed [ACC_W-1:0]          rnd;
	logic signed [ACC_W-1:0]          shifted;
	logic signed [ANGLE_W-1:0]        angle_sat;
	logic signed [ANGLE_W-1:0]        held_cur;
	logic signed [DIFF_W-1:0]         diff;
	logic [DIFF_W-1:0]                mag;
	logic [DIFF_W-1:0]                lim;
	logic                             limited;
	logic signed [DIFF_W-1:0]         held_step;
	logic signed [ANGLE_W-1:0]        held_next;
	logic                             lo_wr;
	logic                             hi_wr;
	logic signed [ANGLE_W-1:0]        lo_next;
	logic signed [ANGLE_W-1:0]        hi_next;

	assign slot_in = slot_of_channel(mux_channel);
	assign idx     = slot_q[IDX_W-1:0];

	always_comb begin
		case (ctrl.cw.mul)
			MUL_COEF_A: mul_a = coef_a(slot_q);
			MUL_T_LO:   mul_a = $signed({1'b0, t_q[T_SPLIT-1:0]});
			MUL_T_HI:   mul_a = $signed({t_q[T_W-1], t_q[T_W-1:T_SPLIT]});
			default:    mul_a = '0;
		endcase
		mul_b    = $signed({1'b0, x_q});
		prod     = mul_a * mul_b;
		prod_t   = {{(T_W - PROD_W){prod[PROD_W-1]}}, prod};
		prod_acc = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
		b_coef   = coef_b(slot_q);
		b_t      = {{(T_W - B_W){b_coef[B_W-1]}}, b_coef};
	end

	always_comb begin
		rnd     = acc_q + RND_HALF;
		shifted = rnd >>> RND_S;
		if (shifted > ACC_W'(ANGLE_MAX)) begin
			angle_sat = ANGLE_MAX;
		end else if (shifted < ACC_W'(ANGLE_MIN)) begin
			angle_sat = ANGLE_MIN;
		end else begin
			angle_sat = shifted[ANGLE_W-1:0];
		end
	end

	always_comb begin
		held_cur  = held_q[idx];
		diff      = DIFF_W'(angle_q) - DIFF_W'(held_cur);
		mag       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		lim       = DIFF_W'(step_limit);
		limited   = (mag >= lim);
		held_step = diff[DIFF_W-1] ? (DIFF_W'(held_cur) - $signed(lim))
			: (DIFF_W'(held_cur) + $signed(lim));
		held_next = limited ? held_step[ANGLE_W-1:0] : angle_q;
	end

	always_comb begin
		lo_wr   = cal_enable && (new_held_q < lo_q[idx]);
		hi_wr   = cal_enable && !lo_wr && (new_held_q > hi_q[idx]);
		lo_next = lo_wr ? new_held_q : lo_q[idx];
		hi_next = hi_wr ? new_held_q : hi_q[idx];
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			slot_q    <= slot_in;
			x_q       <= raw_sample;
			slot_ok_q <= ({1'b0, slot_in} < (SLOT_W + 1)'(CHANNELS));
		end
		case (ctrl.cw.acc)
			ACC_LOAD_T: t_q   <= prod_t + b_t;
			ACC_LOAD_C: acc_q <= prod_acc + coef_c(slot_q);
			ACC_ADD_HI: acc_q <= acc_q + (prod_acc <<< T_SPLIT);
			default: ;
		endcase
		if (ctrl.cw.do_round) begin
			angle_q <= angle_sat;
		end
		if (ctrl.cw.do_slew) begin
			new_held_q <= held_next;
			limited_q  <= limited;
		end
		if (ctrl.emit_go) begin
			out_slot_q <= slot_q;
			if (slot_ok_q) begin
				out_angle_q   <= new_held_q;
				out_limited_q <= limited_q;
				out_min_q     <= lo_next;
				out_max_q     <= hi_next;
			end else begin
				out_angle_q   <= '0;
				out_limited_q <= 1'b0;
				out_min_q     <= '0;
				out_max_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				held_q[i] <= '0;
				lo_q[i]   <= LO_RST;
				hi_q[i]   <= HI_RST;
			end
		end else begin
			if (ctrl.cw.do_slew && slot_ok_q) begin
				held_q[idx] <= held_next;
			end
			if (ctrl.emit_go && slot_ok_q) begin
				lo_q[idx] <= lo_next;
				hi_q[idx] <= hi_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.slot_ok  = slot_ok_q;
	assign status.out_busy = out_valid_q & ~result.ready;

	assign result.valid       = out_valid_q;
	assign result.joint_slot  = out_slot_q;
	assign result.joint_angle = out_angle_q;
	assign result.was_limited = out_limited_q;
	assign result.min_seen    = out_min_q;
	assign result.max_seen    = out_max_q;

endmodule

// ===== design/hall_angle_calibrate_slew_limit.sv =====
// Top level: Hall sensor angle calibration with per-slot slew limit and min/max tracking
//
//  channel  role    word                                          accepted when
//  sample   sink    mux_channel, raw_sample                       valid && ready
//  result   source  joint_slot, joint_angle, was_limited,         valid && ready
//                   min_seen, max_seen
//  cfg      sink    index (0 step_limit, 1 calibrate_enable), data valid && ready
//
// Each word runs one wait step, three multiply steps on the shared 21 x 13 multiplier, then round,
// slew and result steps; a slot of CHANNELS or more skips from the first multiply to the result step.
// The next sample is taken while the previous result waits in the output register; the result
// step holds only while that register is full and not being read.
// Reset clears the step counter, result valid and per-slot state at once; no clearing pass.
`timescale 1ns / 1ps
module hall_angle_calibrate_slew_limit #(
	parameter int CHANNELS  = hacsl_pkg::CHANNELS_DEF,
	parameter int ADC_BITS  = hacsl_pkg::ADC_BITS_DEF,
	parameter int FRAC_BITS = hacsl_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	hacsl_in_if.sink     sample,
	hacsl_out_if.source  result,
	hacsl_cfg_if.sink    cfg
);
	import hacsl_pkg::*;

	logic [LIMIT_W-1:0] step_limit_q;
	logic               cal_enable_q;
	seq_ctrl_t          ctrl;
	dp_status_t         status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= 16'd2304;
			cal_enable_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_STEP_LIMIT: step_limit_q <= cfg.data[LIMIT_W-1:0];
				CFG_CAL_ENABLE: cal_enable_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	hacsl_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.status       (status),
		.ctrl         (ctrl)
	);

	hacsl_datapath #(
		.CHANNELS  (CHANNELS),
		.ADC_BITS  (ADC_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.mux_channel (sample.mux_channel),
		.raw_sample  (sample.raw_sample),
		.step_limit  (step_limit_q),
		.cal_enable  (cal_enable_q),
		.result      (result)
	);

endmodule
